// File: src/hole_fit_allocator_macros.svh
// ---------------------------------------------------------------------------
// hole_fit_allocator_macros
// Assertion shorthands shared by the hole fit allocator RTL.
// ---------------------------------------------------------------------------
`ifndef HOLE_FIT_ALLOCATOR_MACROS_SVH
`define HOLE_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HFA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hole_fit_allocator: assertion failed");

// Next-cycle implication, disabled during reset
`define HFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hole_fit_allocator: assertion failed");

`endif

// File: src/hfa_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hfa_pkg
// Types and codes for the hole fit allocator.
// ---------------------------------------------------------------------------
package hfa_pkg;

  // Input command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Fit policy codes
  localparam logic [1:0] FIT_FIRST  = 2'd0;
  localparam logic [1:0] FIT_WORST  = 2'd1;
  localparam logic [1:0] FIT_BEST   = 2'd2;
  localparam logic [1:0] FIT_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic CFG_FIT_POLICY   = 1'b0;
  localparam logic CFG_HOLES_IN_USE = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } hfa_state_t;

endpackage
`default_nettype wire

// File: src/hfa_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hfa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module hfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: src/hfa_alu.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hfa_alu
// Shared subtract unit: hole minus request, with borrow as the no-fit flag.
// ---------------------------------------------------------------------------
module hfa_alu #(
  parameter int WIDTH = 16
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  output logic      [WIDTH-1:0] diff,
  output logic                  borrow
);

  // Extend by one bit so the top bit of the result is the borrow
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule
`default_nettype wire

// File: src/hole_fit_allocator.sv
// ---------------------------------------------------------------------------
// hole_fit_allocator: hole table with first, worst and best fit allocation
// Load words are written from idle back to back. Allocate, N = holes_in_use capped at
// HOLE_COUNT: scans N holes, skipped for N = 0 or the unused policy; no new word is taken
// until the result is out, which may stall. Reset clears state, config and flags only.
// ---------------------------------------------------------------------------
`default_nettype none
`include "hole_fit_allocator_macros.svh"

module hole_fit_allocator #(
  parameter int HOLE_COUNT = 32,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data,
  // input words
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [4:0]  hole_index,
  input  wire logic [15:0] size_value,
  // result words
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             granted,
  output logic [4:0]       chosen_hole,
  output logic [15:0]      space_left
);

  import hfa_pkg::*;

  localparam int IDX_W  = HOLE_COUNT > 1 ? $clog2(HOLE_COUNT) : 1;
  localparam int CNT_W  = $clog2(HOLE_COUNT + 1);
  localparam int HIU_W  = CNT_W > 6 ? CNT_W : 6;
  localparam int LIDX_W = CNT_W > 5 ? CNT_W : 5;

  // Configuration registers
  logic [1:0] fit_policy;
  logic [5:0] holes_in_use;

  // Sequencer
  hfa_state_t state, state_next;

  // Scan datapath
  logic [SIZE_BITS-1:0] req;
  logic [CNT_W-1:0]     cnt;
  logic [1:0]           policy;
  logic [IDX_W-1:0]     scan_addr;
  logic                 cmp_valid;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_size;
  logic [SIZE_BITS-1:0] best_left;

  // Table and compare unit signals
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [SIZE_BITS-1:0] alu_diff;
  logic                 alu_borrow;

  // Control strobes
  logic                 start_alloc;
  logic                 finish;
  logic                 scan_last;
  logic                 take;
  logic [CNT_W-1:0]     cnt_in;
  logic                 load_in_range;

  hfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (HOLE_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hfa_alu #(
    .WIDTH (SIZE_BITS)
  ) u_alu (
    .a      (rd_data),
    .b      (req),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  // Saturate the active hole count to the table depth
  always_comb begin
    if (HIU_W'(holes_in_use) > HIU_W'(HOLE_COUNT)) begin
      cnt_in = CNT_W'(HOLE_COUNT);
    end else begin
      cnt_in = CNT_W'(holes_in_use);
    end
  end

  assign load_in_range = LIDX_W'(hole_index) < LIDX_W'(HOLE_COUNT);
  assign scan_last     = CNT_W'(scan_addr) == (cnt - CNT_W'(1));

  // Pick rule: first fitting hole, then larger (worst) or smaller (best)
  always_comb begin
    take = 1'b0;
    if (cmp_valid && !alu_borrow) begin
      if (!found) begin
        take = 1'b1;
      end else if (policy == FIT_WORST && rd_data > best_size) begin
        take = 1'b1;
      end else if (policy == FIT_BEST && rd_data < best_size) begin
        take = 1'b1;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy   <= FIT_FIRST;
      holes_in_use <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FIT_POLICY:   fit_policy   <= cfg_data[1:0];
        CFG_HOLES_IN_USE: holes_in_use <= cfg_data;
        default:          ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs
  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    rd_en       = 1'b0;
    rd_addr     = scan_addr;
    wr_en       = 1'b0;
    wr_addr     = best_idx;
    wr_data     = best_left;
    start_alloc = 1'b0;
    finish      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (command == CMD_LOAD) begin
            wr_en   = load_in_range;
            wr_addr = IDX_W'(hole_index);
            wr_data = SIZE_BITS'(size_value);
          end else begin
            start_alloc = 1'b1;
            if (cnt_in == '0 || fit_policy == FIT_UNUSED) begin
              state_next = ST_DONE;
            end else begin
              state_next = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free, then write back
        if (!out_valid || !out_stall) begin
          finish     = 1'b1;
          wr_en      = found;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Scan control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      cmp_valid <= (state == ST_SCAN);
      if (start_alloc) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
    end
  end

  // Scan datapath
  always_ff @(posedge clk) begin
    if (start_alloc) begin
      req       <= SIZE_BITS'(size_value);
      cnt       <= cnt_in;
      policy    <= fit_policy;
      scan_addr <= '0;
      best_idx  <= '0;
      best_size <= '0;
      best_left <= '0;
    end else begin
      if (state == ST_SCAN) begin
        scan_addr <= scan_addr + IDX_W'(1);
      end
      if (take) begin
        best_idx  <= cmp_idx;
        best_size <= rd_data;
        best_left <= alu_diff;
      end
    end
    cmp_idx <= scan_addr;
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      granted     <= found;
      chosen_hole <= found ? 5'(best_idx) : 5'd0;
      space_left  <= found ? 16'(best_left) : 16'd0;
    end
  end

  // Checks
  `HFA_ASSERT_NOW(a_rise_after_done, clk, rst, $rose(out_valid), $past(state) == ST_DONE)
  `HFA_ASSERT_NOW(a_nogrant_zero, clk, rst, out_valid && !granted, ~|{chosen_hole, space_left})
  `HFA_ASSERT_NOW(a_drain_compares, clk, rst, state == ST_DRAIN, cmp_valid)
  `HFA_ASSERT_NOW(a_scan_in_range, clk, rst, state == ST_SCAN, CNT_W'(scan_addr) < cnt)
  `HFA_ASSERT_NEXT(a_result_held, clk, rst, out_valid && out_stall, out_valid && $stable(granted))

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking regression for hole_fit_allocator
// A short table of directed words covers the empty table, zero and full-size
// requests, exact fits, fit ties and every fit policy. Random phases follow.
// Each phase reprograms the policy and the number of holes in use, then
// streams a mix of load and allocate words, with random idling on both sides
// after the opening phases. A behavioral table copy predicts untyped grants,
// and each result word is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
  import hfa_pkg::*;

  localparam int DIR_ROWS    = 22;
  localparam int PHASES      = 40;
  localparam int PHASE_WORDS = 38;
  localparam int SETTLE_CYC  = 40;
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic        granted;
    logic [4:0]  hole;
    logic [15:0] left;
  } grant_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_POLICY, ROW_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        cmd;
    logic [4:0]  idx;
    logic [15:0] size;
    logic        typed;
    grant_t      res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_FIT_POLICY;
  logic [5:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = CMD_LOAD;
  logic [4:0]  hole_index = '0;
  logic [15:0] size_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        granted;
  logic [4:0]  chosen_hole;
  logic [15:0] space_left;

  // Mirror of the block: hole table and configuration
  logic [15:0] hole_tab [32];
  logic [1:0]  fit_mode = FIT_FIRST;
  int          active_holes = 0;

  grant_t   grant_q [$];
  dir_row_t dir_rows [DIR_ROWS];
  bit       calm = 1'b0;
  int       fail_count = 0;
  int       quiet_cycles = 0;

  hole_fit_allocator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .hole_index  (hole_index),
    .size_value  (size_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .granted     (granted),
    .chosen_hole (chosen_hole),
    .space_left  (space_left)
  );

  always #2 clk = ~clk;

  // Pick a hole by the current policy and shrink it
  function automatic grant_t take_hole(input logic [15:0] req);
    grant_t r;
    int     pick;
    r = '0;
    pick = -1;
    if (fit_mode != FIT_UNUSED) begin
      for (int k = 0; k < active_holes; k++) begin
        if (hole_tab[k] >= req) begin
          if (pick < 0)
            pick = k;
          else if (fit_mode == FIT_WORST && hole_tab[k] > hole_tab[pick])
            pick = k;
          else if (fit_mode == FIT_BEST && hole_tab[k] < hole_tab[pick])
            pick = k;
        end
      end
    end
    if (pick >= 0) begin
      hole_tab[pick] = hole_tab[pick] - req;
      r.granted = 1'b1;
      r.hole    = pick[4:0];
      r.left    = hole_tab[pick];
    end
    return r;
  endfunction

  // Offer one input word, idling first at random; update the mirror on accept
  task automatic send_word(input logic cmd, input logic [4:0] idx,
                           input logic [15:0] size, input logic typed,
                           input grant_t typed_res);
    grant_t res;
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    hole_index <= idx;
    size_value <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_LOAD) begin
      hole_tab[idx] = size;
    end else begin
      res = take_hole(size);
      grant_q.push_back(typed ? typed_res : res);
    end
  endtask

  // Drop valid and wait for every predicted result word
  task automatic hold_for_results();
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
  endtask

  // Let a load still in flight finish before reprogramming
  task automatic settle();
    hold_for_results();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_reg(input logic idx, input logic [5:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_FIT_POLICY)
      fit_mode = data[1:0];
    else
      active_holes = (data > 6'd32) ? 32 : int'(data);
    @(posedge clk);
  endtask

  // Result side stall
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 25);
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    grant_t want;
    if (!rst && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        $error("unexpected result word: granted %0d hole %0d left %0d",
               granted, chosen_hole, space_left);
        fail_count++;
      end else begin
        want = grant_q.pop_front();
        if (granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, granted);
          fail_count++;
        end
        if (chosen_hole !== want.hole) begin
          $error("chosen_hole: expected %0d, got %0d", want.hole, chosen_hole);
          fail_count++;
        end
        if (space_left !== want.left) begin
          $error("space_left: expected %0d, got %0d", want.left, space_left);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("hole_fit_allocator regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          r;
    logic [15:0] sz;
    logic [1:0]  pol;
    logic [5:0]  cnt;

    // Directed words; typed results where the answer is obvious
    dir_rows[0]  = '{ROW_WORD, CMD_ALLOC, 5'd0, 16'd5, 1'b1, '{1'b0, 5'd0, 16'd0}};
    dir_rows[1]  = '{ROW_WORD, CMD_LOAD, 5'd0, 16'd100, 1'b0, '0};
    dir_rows[2]  = '{ROW_WORD, CMD_LOAD, 5'd1, 16'd0, 1'b0, '0};
    dir_rows[3]  = '{ROW_WORD, CMD_LOAD, 5'd2, 16'hFFFF, 1'b0, '0};
    dir_rows[4]  = '{ROW_WORD, CMD_LOAD, 5'd3, 16'd300, 1'b0, '0};
    dir_rows[5]  = '{ROW_WORD, CMD_LOAD, 5'd31, 16'h5555, 1'b0, '0};
    dir_rows[6]  = '{ROW_COUNT, CMD_LOAD, 5'd0, 16'd4, 1'b0, '0};
    // zero request fits the first hole and leaves it unchanged
    dir_rows[7]  = '{ROW_WORD, CMD_ALLOC, 5'd31, 16'd0, 1'b1, '{1'b1, 5'd0, 16'd100}};
    // full-size request empties the only hole big enough
    dir_rows[8]  = '{ROW_WORD, CMD_ALLOC, 5'd0, 16'hFFFF, 1'b1, '{1'b1, 5'd2, 16'd0}};
    dir_rows[9]  = '{ROW_WORD, CMD_ALLOC, 5'd0, 16'hFFFF, 1'b1, '{1'b0, 5'd0, 16'd0}};
    dir_rows[10] = '{ROW_POLICY, CMD_LOAD, 5'd0, {14'd0, FIT_WORST}, 1'b0, '0};
    dir_rows[11] = '{ROW_WORD, CMD_ALLOC, 5'd7, 16'd50, 1'b0, '0};
    // tie between two largest holes goes to the lower index
    dir_rows[12] = '{ROW_WORD, CMD_LOAD, 5'd0, 16'd250, 1'b0, '0};
    dir_rows[13] = '{ROW_WORD, CMD_ALLOC, 5'd0, 16'd10, 1'b0, '0};
    dir_rows[14] = '{ROW_POLICY, CMD_LOAD, 5'd0, {14'd0, FIT_BEST}, 1'b0, '0};
    dir_rows[15] = '{ROW_WORD, CMD_ALLOC, 5'd0, 16'd100, 1'b0, '0};
    // zero request under best fit lands in an empty hole
    dir_rows[16] = '{ROW_WORD, CMD_ALLOC, 5'd0, 16'd0, 1'b0, '0};
    dir_rows[17] = '{ROW_POLICY, CMD_LOAD, 5'd0, {14'd0, FIT_UNUSED}, 1'b0, '0};
    dir_rows[18] = '{ROW_WORD, CMD_ALLOC, 5'd0, 16'd0, 1'b1, '{1'b0, 5'd0, 16'd0}};
    dir_rows[19] = '{ROW_POLICY, CMD_LOAD, 5'd0, {14'd0, FIT_FIRST}, 1'b0, '0};
    dir_rows[20] = '{ROW_COUNT, CMD_LOAD, 5'd0, 16'd0, 1'b0, '0};
    dir_rows[21] = '{ROW_WORD, CMD_ALLOC, 5'd0, 16'd0, 1'b1, '{1'b0, 5'd0, 16'd0}};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      case (dir_rows[i].kind)
        ROW_WORD: begin
          send_word(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].size,
                    dir_rows[i].typed, dir_rows[i].res);
        end
        ROW_POLICY: begin
          settle();
          set_reg(CFG_FIT_POLICY, dir_rows[i].size[5:0]);
        end
        default: begin
          settle();
          set_reg(CFG_HOLES_IN_USE, dir_rows[i].size[5:0]);
        end
      endcase
    end

    // Fill the whole table so any holes_in_use setting reads loaded entries
    for (int h = 0; h < 32; h++)
      send_word(CMD_LOAD, h[4:0], 16'($urandom), 1'b0, '0);

    // Random phases, each with its own configuration
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin pol = FIT_FIRST; cnt = 6'd32; end
        1: begin pol = FIT_WORST; cnt = 6'd63; end
        2: begin pol = FIT_BEST;  cnt = 6'd1;  end
        default: begin
          r = $urandom_range(0, 9);
          pol = (r < 3) ? FIT_FIRST : (r < 6) ? FIT_WORST : (r < 9) ? FIT_BEST : FIT_UNUSED;
          r = $urandom_range(0, 19);
          cnt = (r == 0) ? 6'd0 : (r < 3) ? 6'($urandom_range(33, 63)) :
                (r < 8) ? 6'd32 : 6'($urandom_range(1, 32));
        end
      endcase
      set_reg(CFG_FIT_POLICY, {4'd0, pol});
      set_reg(CFG_HOLES_IN_USE, cnt);
      // no idling on either side for the opening phases
      calm = (ph < 3);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph % 8 == 5 && n == 19)
          hold_for_results();
        r = $urandom_range(0, 9);
        if ($urandom_range(0, 1) == 0) begin
          sz = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
               (r < 5) ? 16'($urandom_range(0, 1023)) : 16'($urandom);
          send_word(CMD_LOAD, 5'($urandom_range(0, 31)), sz, 1'b0, '0);
        end else begin
          sz = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
               (r < 4) ? hole_tab[$urandom_range(0, 31)] :
               (r < 7) ? 16'($urandom_range(1, 255)) : 16'($urandom);
          send_word(CMD_ALLOC, 5'($urandom), sz, 1'b0, '0);
        end
      end
    end

    // Drain and report
    hold_for_results();
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0)
      $display("hole_fit_allocator regression: pass");
    else
      $display("hole_fit_allocator regression: fail");
    $finish;
  end

endmodule
